FILE: sv/atab_pkg.sv
package atab_pkg;

  localparam int unsigned BLOCK_W       = 28;
  localparam int unsigned BYTE_W        = 8;
  localparam int unsigned SPT_W         = 6;
  localparam int unsigned HEADS_W       = 5;
  localparam int unsigned HEAD_W        = 4;
  localparam int unsigned CYL_W         = 16;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam int unsigned DIV_STEP_BITS = 4;

  localparam logic [BYTE_W-1:0]  DH_LBA     = 8'hE0;
  localparam logic [BYTE_W-1:0]  DH_CHS     = 8'hA0;
  localparam logic [HEADS_W-1:0] HEADS_MAX  = 5'd16;

  localparam logic [SPT_W-1:0]   SPT_RESET  = 6'd63;
  localparam logic [HEADS_W-1:0] HEADS_RESET = 5'd16;
  localparam logic [CYL_W-1:0]   CYL_RESET  = 16'd16383;

  localparam logic [CFG_IDX_W-1:0] REG_LBA_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPT       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADS     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYLINDERS = 2'd3;

endpackage

FILE: sv/atab_div_pipe.sv
module atab_div_pipe
  import atab_pkg::*;
#(
  parameter int unsigned DIVISOR_W = 6,
  parameter int unsigned SIDE_W    = 45
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [BLOCK_W-1:0]   dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [BLOCK_W-1:0]   quot_o,
  output logic [DIVISOR_W-1:0] rem_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int unsigned NSTAGE = (BLOCK_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

  // restoring division, DIV_STEP_BITS quotient bits per stage;
  // work shifts the dividend out at the top and the quotient in at the bottom
  function automatic logic [DIVISOR_W+BLOCK_W-1:0] div_step(
    input logic [DIVISOR_W-1:0] rem,
    input logic [BLOCK_W-1:0]   work,
    input logic [DIVISOR_W-1:0] dsr,
    input int unsigned          first_bit
  );
    logic [DIVISOR_W:0]   ext;
    logic [DIVISOR_W-1:0] r;
    logic [BLOCK_W-1:0]   w;
    r = rem;
    w = work;
    for (int unsigned j = 0; j < DIV_STEP_BITS; j++) begin
      if (first_bit + j < BLOCK_W) begin
        ext = {r, w[BLOCK_W-1]};
        w   = {w[BLOCK_W-2:0], 1'b0};
        if (ext >= {1'b0, dsr}) begin
          r    = DIVISOR_W'(ext - {1'b0, dsr});
          w[0] = 1'b1;
        end else begin
          r = ext[DIVISOR_W-1:0];
        end
      end
    end
    return {r, w};
  endfunction

  logic [NSTAGE-1:0]    vld_q;
  logic [NSTAGE:0]      stg_ready;
  logic [DIVISOR_W-1:0] rem_q  [NSTAGE];
  logic [BLOCK_W-1:0]   work_q [NSTAGE];
  logic [SIDE_W-1:0]    side_q [NSTAGE];

  assign stg_ready[NSTAGE] = out_ready_i;

  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    logic                 vld_in;
    logic [DIVISOR_W-1:0] rem_in;
    logic [BLOCK_W-1:0]   work_in;
    logic [SIDE_W-1:0]    side_in;
    logic [DIVISOR_W-1:0] rem_d;
    logic [BLOCK_W-1:0]   work_d;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid_i;
      assign rem_in  = '0;
      assign work_in = dividend_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign work_in = work_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign stg_ready[k] = !vld_q[k] || stg_ready[k+1];

    always_comb begin
      {rem_d, work_d} = div_step(rem_in, work_in, divisor_i, k * DIV_STEP_BITS);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (stg_ready[k]) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_ready[k] && vld_in) begin
        rem_q[k]  <= rem_d;
        work_q[k] <= work_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign in_ready_o  = stg_ready[0];
  assign out_valid_o = vld_q[NSTAGE-1];
  assign quot_o      = work_q[NSTAGE-1];
  assign rem_o       = rem_q[NSTAGE-1];
  assign side_o      = side_q[NSTAGE-1];

endmodule

FILE: sv/ata_task_file_address_builder_top.sv
// ATA task-file builder: one item per cycle while back-pressure does not stall it. Two
// seven-stage divider pipelines (four quotient bits a stage) give block / sectors_per_track
// and then track / heads; a final output register forms the task-file bytes and the
// cylinder range check. Every stage moves on its own when the next one is free, so
// bubbles close up and back-pressure stalls nothing that need not stall. Geometry and
// mode are read directly by the pipeline and must be written only while it is empty.
module ata_task_file_address_builder_top
  import atab_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  unit_i,
  input  logic [BLOCK_W-1:0]    block_i,
  input  logic [BYTE_W-1:0]     sector_count_i,
  input  logic [BYTE_W-1:0]     command_code_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [BYTE_W-1:0]     drive_head_o,
  output logic [BYTE_W-1:0]     cylinder_high_o,
  output logic [BYTE_W-1:0]     cylinder_low_o,
  output logic [BYTE_W-1:0]     sector_number_o,
  output logic [BYTE_W-1:0]     count_out_o,
  output logic [BYTE_W-1:0]     command_out_o,
  output logic                  range_error_o
);

  localparam int unsigned SIDE1_W = 1 + BLOCK_W + 2 * BYTE_W;
  localparam int unsigned SIDE2_W = SIDE1_W + SPT_W;

  logic               lba_mode_q;
  logic [SPT_W-1:0]   spt_q;
  logic [HEADS_W-1:0] heads_q;
  logic [CYL_W-1:0]   cyl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lba_mode_q <= 1'b1;
      spt_q      <= SPT_RESET;
      heads_q    <= HEADS_RESET;
      cyl_q      <= CYL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LBA_MODE:  lba_mode_q <= cfg_data_i[0];
        REG_SPT:       spt_q      <= cfg_data_i[SPT_W-1:0];
        REG_HEADS:     heads_q    <= cfg_data_i[HEADS_W-1:0];
        REG_CYLINDERS: cyl_q      <= cfg_data_i[CYL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero reads as one, heads capped at sixteen
  logic [SPT_W-1:0]   spt_eff;
  logic [HEADS_W-1:0] nh_eff;

  assign spt_eff = (spt_q == '0) ? SPT_W'(1) : spt_q;
  always_comb begin
    if (heads_q == '0) begin
      nh_eff = HEADS_W'(1);
    end else if (heads_q > HEADS_MAX) begin
      nh_eff = HEADS_MAX;
    end else begin
      nh_eff = heads_q;
    end
  end

  // stage 1: block / spt
  logic                 d1_valid, d1_ready;
  logic [BLOCK_W-1:0]   track;
  logic [SPT_W-1:0]     sec0;
  logic [SIDE1_W-1:0]   side1;

  atab_div_pipe #(
    .DIVISOR_W (SPT_W),
    .SIDE_W    (SIDE1_W)
  ) u_div_spt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .dividend_i  (block_i),
    .divisor_i   (spt_eff),
    .side_i      ({unit_i, block_i, sector_count_i, command_code_i}),
    .out_valid_o (d1_valid),
    .out_ready_i (d1_ready),
    .quot_o      (track),
    .rem_o       (sec0),
    .side_o      (side1)
  );

  // stage 2: track / heads
  logic                 d2_valid;
  logic                 out_load;
  logic [BLOCK_W-1:0]   cyl_full;
  logic [HEADS_W-1:0]   head_full;
  logic [SIDE2_W-1:0]   side2;

  atab_div_pipe #(
    .DIVISOR_W (HEADS_W),
    .SIDE_W    (SIDE2_W)
  ) u_div_heads (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (d1_valid),
    .in_ready_o  (d1_ready),
    .dividend_i  (track),
    .divisor_i   (nh_eff),
    .side_i      ({side1, sec0}),
    .out_valid_o (d2_valid),
    .out_ready_i (out_load),
    .quot_o      (cyl_full),
    .rem_o       (head_full),
    .side_o      (side2)
  );

  logic               r_unit;
  logic [BLOCK_W-1:0] r_block;
  logic [BYTE_W-1:0]  r_cnt;
  logic [BYTE_W-1:0]  r_cmd;
  logic [SPT_W-1:0]   r_sec;

  assign {r_unit, r_block, r_cnt, r_cmd, r_sec} = side2;

  // output register
  logic              out_vld_q;
  logic [BYTE_W-1:0] dh_d, ch_d, cl_d, sn_d;
  logic              err_d;
  logic [BYTE_W-1:0] dh_q, ch_q, cl_q, sn_q, cnt_q, cmd_q;
  logic              err_q;

  assign out_load = !out_vld_q || out_ready_i;

  always_comb begin
    if (lba_mode_q) begin
      dh_d  = DH_LBA | {3'b000, r_unit, r_block[BLOCK_W-1 -: HEAD_W]};
      ch_d  = r_block[23:16];
      cl_d  = r_block[15:8];
      sn_d  = r_block[7:0];
      err_d = 1'b0;
    end else begin
      dh_d  = DH_CHS | {3'b000, r_unit, head_full[HEAD_W-1:0]};
      ch_d  = cyl_full[15:8];
      cl_d  = cyl_full[7:0];
      sn_d  = BYTE_W'({2'b00, r_sec} + BYTE_W'(1));
      err_d = (cyl_full >= {{(BLOCK_W-CYL_W){1'b0}}, cyl_q});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= d2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && d2_valid) begin
      dh_q  <= dh_d;
      ch_q  <= ch_d;
      cl_q  <= cl_d;
      sn_q  <= sn_d;
      cnt_q <= r_cnt;
      cmd_q <= r_cmd;
      err_q <= err_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign drive_head_o    = dh_q;
  assign cylinder_high_o = ch_q;
  assign cylinder_low_o  = cl_q;
  assign sector_number_o = sn_q;
  assign count_out_o     = cnt_q;
  assign command_out_o   = cmd_q;
  assign range_error_o   = err_q;

`ifndef SYNTHESIS
  a_lba_no_err : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && lba_mode_q |-> !range_error_o)
    else $error("range error raised in LBA mode");

  a_dh_fixed_bits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> drive_head_o[7] && drive_head_o[5])
    else $error("drive/head fixed bits missing");

  a_chs_sector : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lba_mode_q |->
      sector_number_o != '0 && sector_number_o <= {2'b00, spt_eff})
    else $error("CHS sector outside track");

  a_chs_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !lba_mode_q |-> {1'b0, drive_head_o[3:0]} < nh_eff)
    else $error("CHS head outside geometry");
`endif

endmodule
